// ===== hw/rtl/fqkr_pkg.sv =====
// Package for the keyed-remove FIFO queue: operation and status codes,
// transaction structs for the command and result ports, and the cell control struct.
// No dependencies.
package fqkr_pkg;

  // Widths of the port fields; these do not vary with the module parameters.
  localparam int unsigned OpW       = 2;
  localparam int unsigned FieldW    = 16;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned OccW      = 5;

  typedef enum logic [OpW-1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_FIND   = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2
  } status_e;

  // One command transaction.
  typedef struct packed {
    op_e               op;
    logic [FieldW-1:0] item_handle;
    logic [FieldW-1:0] item_id;
    logic [FieldW-1:0] search_id;
  } cmd_t;

  // One result transaction.
  typedef struct packed {
    status_e           status;
    logic              found;
    logic [FieldW-1:0] result_handle;
    logic [OccW-1:0]   occupancy;
  } result_t;

  // Per-cell control from the top level.
  typedef struct packed {
    logic exec;
    op_e  op;
    logic head;
    logic occupied;
    logic tail;
  } cell_ctl_t;

endpackage

// ===== hw/rtl/fqkr_cell.sv =====
// One slot of the keyed-remove FIFO: holds an identifier and a handle,
// compares against the key and passes the first-hit flag down the row.
// Depends on fqkr_pkg.
module fqkr_cell #(
  parameter int unsigned ID_BITS     = 16,
  parameter int unsigned HANDLE_BITS = 16
) (
  input  logic                   clk_i,
  input  fqkr_pkg::cell_ctl_t    ctl_i,
  input  logic [ID_BITS-1:0]     key_i,
  input  logic [ID_BITS-1:0]     push_id_i,
  input  logic [HANDLE_BITS-1:0] push_handle_i,
  input  logic [ID_BITS-1:0]     next_id_i,
  input  logic [HANDLE_BITS-1:0] next_handle_i,
  input  logic                   hit_i,
  input  logic [HANDLE_BITS-1:0] handle_i,
  output logic                   hit_o,
  output logic [HANDLE_BITS-1:0] handle_o,
  output logic [ID_BITS-1:0]     slot_id_o,
  output logic [HANDLE_BITS-1:0] slot_handle_o
);

  logic [ID_BITS-1:0]     id_q, id_d;
  logic [HANDLE_BITS-1:0] hnd_q, hnd_d;
  logic                   hit_here;
  logic                   first_hit;
  logic                   shift;

  // A pop hits the head cell; remove and find hit on an identifier match.
  always_comb begin
    unique case (ctl_i.op)
      fqkr_pkg::OP_POP:    hit_here = ctl_i.occupied & ctl_i.head;
      fqkr_pkg::OP_REMOVE: hit_here = ctl_i.occupied & (id_q == key_i);
      fqkr_pkg::OP_FIND:   hit_here = ctl_i.occupied & (id_q == key_i);
      default:             hit_here = 1'b0;
    endcase
  end

  // Only the hit nearest the head contributes its handle.
  assign first_hit = hit_here & ~hit_i;
  assign hit_o     = hit_i | hit_here;
  assign handle_o  = handle_i | (first_hit ? hnd_q : '0);

  // Cells at and behind the taken entry pull their neighbor's contents.
  assign shift = ((ctl_i.op == fqkr_pkg::OP_POP) || (ctl_i.op == fqkr_pkg::OP_REMOVE)) & hit_o;

  always_comb begin
    id_d  = id_q;
    hnd_d = hnd_q;
    if (ctl_i.exec) begin
      if ((ctl_i.op == fqkr_pkg::OP_PUSH) && ctl_i.tail) begin
        id_d  = push_id_i;
        hnd_d = push_handle_i;
      end else if (shift) begin
        id_d  = next_id_i;
        hnd_d = next_handle_i;
      end
    end
  end

  // Slot contents carry no reset.
  always_ff @(posedge clk_i) begin
    id_q  <= id_d;
    hnd_q <= hnd_d;
  end

  assign slot_id_o     = id_q;
  assign slot_handle_o = hnd_q;

endmodule

// ===== hw/rtl/fifo_queue_with_keyed_remove_core.sv =====
// Top level of the keyed-remove FIFO queue: command register, entry count,
// row of fqkr_cell slots and the result register. Depends on fqkr_pkg, fqkr_cell.
//
// Usage:
//   A command transaction (push, pop, remove by id, find by id) is taken at a
//   rising edge where start is high and busy is low. busy is high for the one
//   cycle that follows, while the cell row evaluates the command and updates.
//   The result transaction appears on result_o with result_valid_o high for
//   exactly one cycle, registered from busy, and cannot be held off by the
//   receiver. A new command may be started in that same cycle.
//   A new command is not taken while busy is high. The execute cycle is set
//   by the first-hit flag and handle that ripple through all DEPTH cells of
//   the row. Reset clears the entry count, busy and the result strobe; slot
//   contents are not cleared, since only slots below the count are ever read.
module fifo_queue_with_keyed_remove_core #(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned ID_BITS     = 16,
  parameter int unsigned HANDLE_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  fqkr_pkg::cmd_t     cmd_i,
  output logic               result_valid_o,
  output fqkr_pkg::result_t  result_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic                   accept;
  logic                   busy_q;
  fqkr_pkg::op_e          op_q;
  logic [ID_BITS-1:0]     id_q, key_q;
  logic [HANDLE_BITS-1:0] hnd_q;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic                   full;
  logic                   res_valid_q;
  fqkr_pkg::result_t      res_q, res_d;

  logic [ID_BITS-1:0]     slot_id   [DEPTH];
  logic [HANDLE_BITS-1:0] slot_hnd  [DEPTH];
  logic                   hit_c     [DEPTH+1];
  logic [HANDLE_BITS-1:0] hnd_c     [DEPTH+1];

  assign accept = start & ~busy_q;
  assign busy   = busy_q;
  assign full   = (cnt_q == CntW'(DEPTH));

  // Command register; fields are truncated or extended to the stored widths.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= cmd_i.op;
      id_q  <= ID_BITS'(cmd_i.item_id);
      key_q <= ID_BITS'(cmd_i.search_id);
      hnd_q <= HANDLE_BITS'(cmd_i.item_handle);
    end
  end

  // Row of cells; the hit flag and handle ripple from head to tail.
  assign hit_c[0] = 1'b0;
  assign hnd_c[0] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    fqkr_pkg::cell_ctl_t    ctl;
    logic [ID_BITS-1:0]     nxt_id;
    logic [HANDLE_BITS-1:0] nxt_hnd;

    assign ctl.exec     = busy_q;
    assign ctl.op       = op_q;
    assign ctl.head     = (i == 0);
    assign ctl.occupied = (cnt_q > CntW'(i));
    assign ctl.tail     = (cnt_q == CntW'(i));

    if (i + 1 < DEPTH) begin : g_next
      assign nxt_id  = slot_id[i+1];
      assign nxt_hnd = slot_hnd[i+1];
    end else begin : g_last
      assign nxt_id  = slot_id[i];
      assign nxt_hnd = slot_hnd[i];
    end

    fqkr_cell #(
      .ID_BITS     (ID_BITS),
      .HANDLE_BITS (HANDLE_BITS)
    ) u_cell (
      .clk_i         (clk_i),
      .ctl_i         (ctl),
      .key_i         (key_q),
      .push_id_i     (id_q),
      .push_handle_i (hnd_q),
      .next_id_i     (nxt_id),
      .next_handle_i (nxt_hnd),
      .hit_i         (hit_c[i]),
      .handle_i      (hnd_c[i]),
      .hit_o         (hit_c[i+1]),
      .handle_o      (hnd_c[i+1]),
      .slot_id_o     (slot_id[i]),
      .slot_handle_o (slot_hnd[i])
    );
  end

  // Count update and result formation in the execute cycle.
  always_comb begin
    cnt_d               = cnt_q;
    res_d.status        = fqkr_pkg::ST_NOTFOUND;
    res_d.found         = 1'b0;
    res_d.result_handle = fqkr_pkg::FieldW'(hnd_c[DEPTH]);
    unique case (op_q)
      fqkr_pkg::OP_PUSH: begin
        if (full) begin
          res_d.status = fqkr_pkg::ST_FULL;
        end else begin
          res_d.status = fqkr_pkg::ST_OK;
          cnt_d        = cnt_q + CntW'(1);
        end
      end
      fqkr_pkg::OP_POP, fqkr_pkg::OP_REMOVE: begin
        if (hit_c[DEPTH]) begin
          res_d.status = fqkr_pkg::ST_OK;
          res_d.found  = 1'b1;
          cnt_d        = cnt_q - CntW'(1);
        end
      end
      default: begin
        if (hit_c[DEPTH]) begin
          res_d.status = fqkr_pkg::ST_OK;
          res_d.found  = 1'b1;
        end
      end
    endcase
    res_d.occupancy = fqkr_pkg::OccW'(cnt_d);
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      res_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      busy_q      <= accept;
      res_valid_q <= busy_q;
      if (busy_q) begin
        cnt_q <= cnt_d;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      res_q <= res_d;
    end
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

// ===== hw/rtl/fqkr_checker.sv =====
// Port-level checker for the keyed-remove FIFO queue and its bind to the top level.
// Depends on fqkr_pkg and fifo_queue_with_keyed_remove_core.
module fqkr_port_checker #(
  parameter int unsigned DEPTH = 16
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              result_valid_o,
  input fqkr_pkg::result_t result_o
);

  // An accepted transaction yields its result strobe after its busy cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> ##1 result_valid_o)
    else $error("result strobe missing after accepted transaction");

  // A strobe only follows a busy cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("result strobe without a preceding busy cycle");

  // A full status, from a dropped push, reports occupancy at DEPTH and no found entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (result_o.status == fqkr_pkg::ST_FULL)) |->
      (result_o.occupancy == fqkr_pkg::OccW'(DEPTH)) && !result_o.found)
    else $error("full status with occupancy below depth");

  // A miss returns a zero handle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.found) |-> (result_o.result_handle == '0))
    else $error("nonzero handle without a found entry");

endmodule

bind fifo_queue_with_keyed_remove_core fqkr_port_checker #(
  .DEPTH (DEPTH)
) u_fqkr_port_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);
